[rtl/core/eqrf_pkg.sv]
// ----------------------------------------------------------------------------
// eqrf_pkg
// shared types and constants of the event queue record formatter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eqrf_pkg;

  // default configuration
  localparam int unsigned DEF_QUEUE_DEPTH   = 16;
  localparam int unsigned DEF_HEADER_BYTES  = 16;
  localparam int unsigned DEF_ID_OFFSET     = 0;
  localparam int unsigned DEF_LENGTH_OFFSET = 4;

  // fixed field widths
  localparam int unsigned EVENT_W   = 32;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned REC_LEN_W = 7;
  localparam int unsigned MASK_W    = 16;

  // legacy record is a two-byte mask
  localparam logic [REC_LEN_W-1:0] LEGACY_BYTES = 7'd2;

  typedef enum logic [1:0] {
    KIND_ENQUEUE = 2'd0,
    KIND_READ    = 2'd1,
    KIND_CONSUME = 2'd2,
    KIND_STATUS  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PROF_NONE   = 2'd0,
    PROF_LEGACY = 2'd1,
    PROF_FRAMED = 2'd2
  } prof_t;

  // current record contents as seen by the byte selector
  typedef struct packed {
    prof_t              profile;
    logic [MASK_W-1:0]  legacy_mask;
    logic [EVENT_W-1:0] framed_id;
  } rec_t;

endpackage

`default_nettype wire

[rtl/core/event_queue_record_formatter_unit.sv]
// ----------------------------------------------------------------------------
// event_queue_record_formatter_unit
// event queue with legacy mask / framed header readout
// ----------------------------------------------------------------------------
// usage:
//   one request enters on the in_ stream: kind in in_tuser, event id and byte
//   count in in_tdata. every request gives one or more results on the out_
//   stream; out_tlast marks the final result of a request.
//   enqueue: the request is accepted, the queue is written, then the result is
//   loaded. status and consume pass the same states. a read of an existing
//   record is accepted, executed and prepared, then gives one result per
//   returned byte. a read that builds a framed record adds a state for the
//   memory read of the head entry; a legacy mask build walks the queue memory
//   one entry per cycle through its single read port.
//   one request is worked at a time; the next one is taken as soon as the
//   sequencer is back in idle, even while the last result still sits in the
//   output register.
//   reset (synchronous, rst_n low) empties the queue, clears the record and
//   forgets the detected profile; the queue memory itself is not cleared.
//   a stalled receiver holds the output register; byte emission waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module event_queue_record_formatter_unit
  import eqrf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int unsigned HEADER_BYTES  = DEF_HEADER_BYTES,
  parameter int unsigned ID_OFFSET     = DEF_ID_OFFSET,
  parameter int unsigned LENGTH_OFFSET = DEF_LENGTH_OFFSET
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // event_id [31:0], byte_count [47:32]
  input  wire logic [1:0]  in_tuser,   // kind [1:0]

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // data_byte [7:0], readable [8],
                                       // pending_bytes [15:9], profile [17:16],
                                       // dropped [18], zero [23:19]
  output logic [0:0]       out_tuser,  // byte_valid [0]
  output logic             out_tlast   // last result of the request
);

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = $clog2(2 * QUEUE_DEPTH);

  localparam logic [CW-1:0]        DEPTH_C  = CW'(QUEUE_DEPTH);
  localparam logic [QW-1:0]        LAST_IDX = QW'(QUEUE_DEPTH - 1);
  localparam logic [SW-1:0]        DEPTH_S  = SW'(QUEUE_DEPTH);
  localparam logic [REC_LEN_W-1:0] HDR_LEN  = REC_LEN_W'(HEADER_BYTES);

  // one-hot sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_FRAME = 7'b0001000,
    S_PREP  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // queue memory, one write and one registered read port
  logic [EVENT_W-1:0] queue_mem [QUEUE_DEPTH];
  logic [EVENT_W-1:0] rdata_r;
  logic [QW-1:0]      rd_addr;
  logic [QW-1:0]      wr_addr;
  logic               mem_we;

  // queue and record state
  logic [QW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  prof_t                profile_r, profile_nxt;
  logic [REC_LEN_W-1:0] length_r, length_nxt;
  logic [REC_LEN_W-1:0] offset_r, offset_nxt;
  logic [CW-1:0]        rec_events_r, rec_events_nxt;
  logic [MASK_W-1:0]    mask_r, mask_nxt;
  logic [EVENT_W-1:0]   framed_r, framed_nxt;

  // latched request
  kind_t                kind_r, kind_nxt;
  logic [EVENT_W-1:0]   ev_r, ev_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 drop_r, drop_nxt;

  // legacy scan walker
  logic [QW-1:0]        scan_ptr_r, scan_ptr_nxt;
  logic [CW-1:0]        scan_left_r, scan_left_nxt;
  logic                 rd_pend_r, rd_pend_nxt;

  // byte emission
  logic [REC_LEN_W-1:0] emit_pos_r, emit_pos_nxt;
  logic [REC_LEN_W-1:0] emit_end_r, emit_end_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_byte_r, out_byte_nxt;
  logic                 out_bvalid_r, out_bvalid_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_read_r, out_read_nxt;
  logic [REC_LEN_W-1:0] out_pend_r, out_pend_nxt;
  prof_t                out_prof_r, out_prof_nxt;
  logic                 out_drop_r, out_drop_nxt;

  logic                 slot_free;
  logic                 in_acc;
  logic                 readable;
  logic [REC_LEN_W-1:0] pending;
  logic [REC_LEN_W-1:0] rem;
  logic [SW-1:0]        tail_sum;
  logic [SW-1:0]        pop_sum;
  logic [CW-1:0]        pop_n;
  logic [MASK_W-1:0]    ev_bit;
  prof_t                prof_eff;
  rec_t                 rec;
  logic [BYTE_W-1:0]    rec_byte;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // status after the request, taken from the state registers
  assign readable = (offset_r < length_r) || (count_r != '0);
  assign rem      = (length_r > offset_r) ? (length_r - offset_r) : '0;

  always_comb begin
    if (offset_r < length_r) begin
      pending = length_r - offset_r;
    end else if (count_r == '0) begin
      pending = '0;
    end else begin
      pending = (profile_r == PROF_LEGACY) ? LEGACY_BYTES : HDR_LEN;
    end
  end

  // circular slot arithmetic, sums stay below twice the depth
  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign wr_addr  = (tail_sum >= DEPTH_S) ? QW'(tail_sum - DEPTH_S) : QW'(tail_sum);
  assign pop_n    = (rec_events_r < count_r) ? rec_events_r : count_r;
  assign pop_sum  = SW'(head_r) + SW'(pop_n);

  // first read fixes the profile from its capacity
  assign prof_eff = (profile_r != PROF_NONE) ? profile_r :
                    (cnt_r <= COUNT_W'(LEGACY_BYTES)) ? PROF_LEGACY : PROF_FRAMED;

  // mask bit of a scanned event, codes 1 to 16 only
  assign ev_bit = (rdata_r != '0 && rdata_r <= EVENT_W'(MASK_W)) ?
                  (MASK_W'(1) << (rdata_r[3:0] - 4'd1)) : '0;

  assign rd_addr = (state_r == S_SCAN) ? scan_ptr_r : head_r;
  assign mem_we  = (state_r == S_EXEC) && (kind_r == KIND_ENQUEUE) &&
                   (ev_r != '0) && (count_r < DEPTH_C);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      queue_mem[wr_addr] <= ev_r;
    end
    rdata_r <= queue_mem[rd_addr];
  end

  assign rec.profile     = profile_r;
  assign rec.legacy_mask = mask_r;
  assign rec.framed_id   = framed_r;

  eqrf_byte_sel #(
    .ID_OFFSET     (ID_OFFSET),
    .LENGTH_OFFSET (LENGTH_OFFSET)
  ) u_byte_sel (
    .rec      (rec),
    .byte_idx (emit_pos_r),
    .rec_byte (rec_byte)
  );

  always_comb begin
    logic [REC_LEN_W-1:0] take;
    logic [REC_LEN_W-1:0] off_new;

    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    profile_nxt    = profile_r;
    length_nxt     = length_r;
    offset_nxt     = offset_r;
    rec_events_nxt = rec_events_r;
    mask_nxt       = mask_r;
    framed_nxt     = framed_r;
    kind_nxt       = kind_r;
    ev_nxt         = ev_r;
    cnt_nxt        = cnt_r;
    drop_nxt       = drop_r;
    scan_ptr_nxt   = scan_ptr_r;
    scan_left_nxt  = scan_left_r;
    rd_pend_nxt    = 1'b0;
    emit_pos_nxt   = emit_pos_r;
    emit_end_nxt   = emit_end_r;

    out_valid_nxt  = out_valid_r && !out_tready;
    out_byte_nxt   = out_byte_r;
    out_bvalid_nxt = out_bvalid_r;
    out_last_nxt   = out_last_r;
    out_read_nxt   = out_read_r;
    out_pend_nxt   = out_pend_r;
    out_prof_nxt   = out_prof_r;
    out_drop_nxt   = out_drop_r;

    take    = '0;
    off_new = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt  = kind_t'(in_tuser);
          ev_nxt    = in_tdata[31:0];
          cnt_nxt   = in_tdata[47:32];
          drop_nxt  = 1'b0;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_RESP;
        unique case (kind_r)
          KIND_ENQUEUE: begin
            if (ev_r != '0) begin
              if (count_r < DEPTH_C) begin
                count_nxt = count_r + CW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
          end
          KIND_READ: begin
            if (cnt_r != '0 && readable) begin
              profile_nxt = prof_eff;
              if (offset_r >= length_r) begin
                if (prof_eff == PROF_LEGACY) begin
                  // walk every queued event into the mask
                  mask_nxt      = '0;
                  scan_ptr_nxt  = head_r;
                  scan_left_nxt = count_r;
                  state_nxt     = S_SCAN;
                end else begin
                  // head entry is being read this cycle
                  state_nxt = S_FRAME;
                end
              end else begin
                state_nxt = S_PREP;
              end
            end
          end
          KIND_CONSUME: begin
            take    = (cnt_r < COUNT_W'(rem)) ? cnt_r[REC_LEN_W-1:0] : rem;
            off_new = offset_r + take;
            if (off_new >= length_r) begin
              head_nxt       = (pop_sum >= DEPTH_S) ? QW'(pop_sum - DEPTH_S)
                                                    : QW'(pop_sum);
              count_nxt      = count_r - pop_n;
              length_nxt     = '0;
              offset_nxt     = '0;
              rec_events_nxt = '0;
            end else begin
              offset_nxt = off_new;
            end
          end
          default: begin
            // status only
          end
        endcase
      end

      S_SCAN: begin
        if (rd_pend_r) begin
          mask_nxt = mask_r | ev_bit;
        end
        if (scan_left_r != '0) begin
          scan_left_nxt = scan_left_r - CW'(1);
          scan_ptr_nxt  = (scan_ptr_r == LAST_IDX) ? '0 : scan_ptr_r + QW'(1);
          rd_pend_nxt   = 1'b1;
        end else if (!rd_pend_r) begin
          length_nxt     = LEGACY_BYTES;
          offset_nxt     = '0;
          rec_events_nxt = count_r;
          state_nxt      = S_PREP;
        end
      end

      S_FRAME: begin
        framed_nxt     = rdata_r;
        length_nxt     = HDR_LEN;
        offset_nxt     = '0;
        rec_events_nxt = CW'(1);
        state_nxt      = S_PREP;
      end

      S_PREP: begin
        take         = (cnt_r < COUNT_W'(rem)) ? cnt_r[REC_LEN_W-1:0] : rem;
        emit_pos_nxt = offset_r;
        emit_end_nxt = offset_r + take;
        state_nxt    = S_EMIT;
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = rec_byte;
          out_bvalid_nxt = 1'b1;
          out_last_nxt   = (emit_pos_r + REC_LEN_W'(1)) == emit_end_r;
          out_read_nxt   = readable;
          out_pend_nxt   = pending;
          out_prof_nxt   = profile_r;
          out_drop_nxt   = 1'b0;
          emit_pos_nxt   = emit_pos_r + REC_LEN_W'(1);
          if ((emit_pos_r + REC_LEN_W'(1)) == emit_end_r) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = '0;
          out_bvalid_nxt = 1'b0;
          out_last_nxt   = 1'b1;
          out_read_nxt   = readable;
          out_pend_nxt   = pending;
          out_prof_nxt   = profile_r;
          out_drop_nxt   = drop_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      profile_r    <= PROF_NONE;
      length_r     <= '0;
      offset_r     <= '0;
      rec_events_r <= '0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      profile_r    <= profile_nxt;
      length_r     <= length_nxt;
      offset_r     <= offset_nxt;
      rec_events_r <= rec_events_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mask_r       <= mask_nxt;
    framed_r     <= framed_nxt;
    kind_r       <= kind_nxt;
    ev_r         <= ev_nxt;
    cnt_r        <= cnt_nxt;
    drop_r       <= drop_nxt;
    scan_ptr_r   <= scan_ptr_nxt;
    scan_left_r  <= scan_left_nxt;
    emit_pos_r   <= emit_pos_nxt;
    emit_end_r   <= emit_end_nxt;
    out_byte_r   <= out_byte_nxt;
    out_bvalid_r <= out_bvalid_nxt;
    out_last_r   <= out_last_nxt;
    out_read_r   <= out_read_nxt;
    out_pend_r   <= out_pend_nxt;
    out_prof_r   <= out_prof_nxt;
    out_drop_r   <= out_drop_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_drop_r, out_prof_r, out_pend_r, out_read_r, out_byte_r};
  assign out_tuser  = out_bvalid_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[rtl/core/eqrf_byte_sel.sv]
// ----------------------------------------------------------------------------
// eqrf_byte_sel
// picks one byte of the current legacy or framed record
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eqrf_byte_sel
  import eqrf_pkg::*;
#(
  parameter int unsigned ID_OFFSET     = DEF_ID_OFFSET,
  parameter int unsigned LENGTH_OFFSET = DEF_LENGTH_OFFSET
) (
  input  var rec_t                  rec,
  input  wire logic [REC_LEN_W-1:0] byte_idx,
  output logic      [BYTE_W-1:0]    rec_byte
);

  localparam logic [REC_LEN_W-1:0] ID_LO  = REC_LEN_W'(ID_OFFSET);
  localparam logic [REC_LEN_W-1:0] ID_HI  = REC_LEN_W'(ID_OFFSET + 4);
  localparam logic [REC_LEN_W-1:0] LEN_LO = REC_LEN_W'(LENGTH_OFFSET);
  localparam logic [REC_LEN_W-1:0] LEN_HI = REC_LEN_W'(LENGTH_OFFSET + 4);

  logic [REC_LEN_W-1:0] id_rel;

  assign id_rel = byte_idx - ID_LO;

  always_comb begin
    rec_byte = '0;
    if (rec.profile == PROF_LEGACY) begin
      rec_byte = (byte_idx == '0) ? rec.legacy_mask[7:0] : rec.legacy_mask[15:8];
    end else if (byte_idx >= LEN_LO && byte_idx < LEN_HI) begin
      // length field is zero and overrides the id where they overlap
      rec_byte = '0;
    end else if (byte_idx >= ID_LO && byte_idx < ID_HI) begin
      unique case (id_rel[1:0])
        2'd0:    rec_byte = rec.framed_id[7:0];
        2'd1:    rec_byte = rec.framed_id[15:8];
        2'd2:    rec_byte = rec.framed_id[23:16];
        default: rec_byte = rec.framed_id[31:24];
      endcase
    end
  end

endmodule

`default_nettype wire
